[src/nearest_neighbor_image_scaler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest neighbour image scaler
// Clocked concurrent checks with reset disable, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH

// Overlapping implication: consequent checked in the same cycle.
`define NNIS_AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Non-overlapping implication: consequent checked in the next cycle.
`define NNIS_AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

[src/nnis_pkg.sv]
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared constants, register indexes and control types of the image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int SIZE_W    = 13;
    localparam int RATIO_W   = 23;
    localparam int FRAC_BITS = 16;
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 3 * CHAN_W;
    localparam int IDX_W     = 2 * SIZE_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = RATIO_W;

    localparam int DEF_PIXEL_CAPACITY = 65536;
    localparam int DEF_COORD_BITS     = 12;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd1;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 23'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_RATIO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RATIO    = 3'd5;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PRODUCE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // store one source pixel
        logic start;   // capture counters, multiply, advance counters
        logic clamp;   // clamp scaled coordinates
        logic index;   // form linear source index
        logic read;    // read pixel store
        logic emit;    // load output register
    } ctl_cmd_t;

    // A size of zero behaves as one
    function automatic logic [SIZE_W-1:0] at_least_one(input logic [SIZE_W-1:0] v);
        at_least_one = (v == '0) ? SIZE_RESET : v;
    endfunction

endpackage

[src/nnis_in_if.sv]
// ----------------------------------------------------------------------------
// nnis_in_if
// Input channel: load or produce command with a source pixel.
// ----------------------------------------------------------------------------
interface nnis_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output cmd, output blue, output green, output red,
                    input ready);
    modport sink   (input valid, input cmd, input blue, input green, input red,
                    output ready);
endinterface

[src/nnis_out_if.sv]
// ----------------------------------------------------------------------------
// nnis_out_if
// Output channel: one destination pixel with its coordinates.
// ----------------------------------------------------------------------------
interface nnis_out_if #(
    parameter int COORD_BITS = nnis_pkg::DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [7:0]            out_blue;
    logic [7:0]            out_green;
    logic [7:0]            out_red;
    logic [COORD_BITS-1:0] dest_col;
    logic [COORD_BITS-1:0] dest_row;
    logic                  frame_end;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output dest_col, output dest_row, output frame_end, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input dest_col, input dest_row, input frame_end, output ready);
endinterface

[src/nnis_cfg_if.sv]
// ----------------------------------------------------------------------------
// nnis_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface nnis_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nnis_pkg::CFG_IDX_W-1:0]   index;
    logic [nnis_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/nearest_neighbor_image_scaler_unit.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit
// Nearest neighbour scaler: loads a BGR source image, emits scaled pixels.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                           | role
//  req     | in  | cmd, blue, green, red                             | load / produce
//  rsp     | out | out_blue, out_green, out_red, dest_col, dest_row, | scaled pixel
//          |     | frame_end                                         |
//  cfg     | in  | index, data                                       | register write
//
//  Load transaction: one pixel store write port access.
//  Produce transaction: multiply, clamp, index multiply-add, registered store
//  read, then output register load; req is held off until the result has
//  moved into the output register.
//  Output register decouples rsp stalls; loads are taken while a result waits.
//  Reset (rst_n, async) clears counters, config, control; not work regs or store.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nearest_neighbor_image_scaler_unit #(
    parameter int PIXEL_CAPACITY = nnis_pkg::DEF_PIXEL_CAPACITY,
    parameter int COORD_BITS     = nnis_pkg::DEF_COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    nnis_in_if.sink       req,
    nnis_out_if.source    rsp,
    nnis_cfg_if.sink      cfg
);

    nnis_pkg::ctl_cmd_t ctl_cmd;

    assign cfg.ready = 1'b1;

    nnis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_cmd    (req.cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctl_cmd)
    );

    nnis_dp #(
        .PIXEL_CAPACITY (PIXEL_CAPACITY),
        .COORD_BITS     (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_blue   (req.blue),
        .in_green  (req.green),
        .in_red    (req.red),
        .out_blue  (rsp.out_blue),
        .out_green (rsp.out_green),
        .out_red   (rsp.out_red),
        .dest_col  (rsp.dest_col),
        .dest_row  (rsp.dest_row),
        .frame_end (rsp.frame_end)
    );

    `NNIS_AST_NXT(a_prod_holds_req, clk, rst_n, req.valid && req.ready && req.cmd, !req.ready, "req ready right after produce")
    `NNIS_AST_IMP(a_prod_latency, clk, rst_n, req.valid && req.ready && req.cmd, ##3 !req.ready, "produce finished too early")
    `NNIS_AST_NXT(a_load_silent, clk, rst_n, req.valid && req.ready && !req.cmd && !rsp.valid, !rsp.valid, "load made a result")

endmodule

[src/nnis_pixel_store.sv]
// ----------------------------------------------------------------------------
// nnis_pixel_store
// Single port write, single port read pixel memory with registered read data.
// ----------------------------------------------------------------------------
module nnis_pixel_store #(
    parameter int DEPTH = nnis_pkg::DEF_PIXEL_CAPACITY
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [nnis_pkg::PIXEL_W-1:0]  wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [nnis_pkg::PIXEL_W-1:0]  rdata
);

    logic [nnis_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [nnis_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/nnis_ctrl.sv]
// ----------------------------------------------------------------------------
// nnis_ctrl
// Sequencer for load and produce transactions and output register valid.
// ----------------------------------------------------------------------------
module nnis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nnis_pkg::ctl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_INDEX = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd       = '0;
        cmd.load  = accept && (in_cmd == nnis_pkg::CMD_LOAD);
        cmd.start = accept && (in_cmd == nnis_pkg::CMD_PRODUCE);
        cmd.clamp = (state_reg == ST_CLAMP);
        cmd.index = (state_reg == ST_INDEX);
        cmd.read  = (state_reg == ST_READ);
        cmd.emit  = (state_reg == ST_DONE) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_INDEX;
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/nnis_dp.sv]
// ----------------------------------------------------------------------------
// nnis_dp
// Scaler datapath: config registers, counters, coordinate mapping, store.
// ----------------------------------------------------------------------------
module nnis_dp #(
    parameter int PIXEL_CAPACITY = nnis_pkg::DEF_PIXEL_CAPACITY,
    parameter int COORD_BITS     = nnis_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nnis_pkg::ctl_cmd_t                cmd,
    input  logic                              cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [nnis_pkg::CHAN_W-1:0]       in_blue,
    input  logic [nnis_pkg::CHAN_W-1:0]       in_green,
    input  logic [nnis_pkg::CHAN_W-1:0]       in_red,
    output logic [nnis_pkg::CHAN_W-1:0]       out_blue,
    output logic [nnis_pkg::CHAN_W-1:0]       out_green,
    output logic [nnis_pkg::CHAN_W-1:0]       out_red,
    output logic [COORD_BITS-1:0]             dest_col,
    output logic [COORD_BITS-1:0]             dest_row,
    output logic                              frame_end
);

    localparam int SIZE_W  = nnis_pkg::SIZE_W;
    localparam int RATIO_W = nnis_pkg::RATIO_W;
    localparam int IDX_W   = nnis_pkg::IDX_W;
    localparam int CHAN_W  = nnis_pkg::CHAN_W;
    localparam int ADDR_W  = $clog2(PIXEL_CAPACITY);
    localparam int LC_W    = $clog2(PIXEL_CAPACITY + 1);
    localparam int PROD_W  = COORD_BITS + RATIO_W;
    localparam int SCL_W   = PROD_W - nnis_pkg::FRAC_BITS;
    localparam int CMP_W   = (SCL_W > SIZE_W) ? SCL_W : SIZE_W;
    localparam int EDGE_W  = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;

    // configuration
    logic [SIZE_W-1:0]  src_width_reg;
    logic [SIZE_W-1:0]  src_height_reg;
    logic [SIZE_W-1:0]  dst_width_reg;
    logic [SIZE_W-1:0]  dst_height_reg;
    logic [RATIO_W-1:0] x_ratio_reg;
    logic [RATIO_W-1:0] y_ratio_reg;

    // state
    logic [LC_W-1:0]       load_count_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;

    // work registers
    logic [COORD_BITS-1:0] dcol_reg;
    logic [COORD_BITS-1:0] drow_reg;
    logic                  fend_reg;
    logic [PROD_W-1:0]     prod_x_reg;
    logic [PROD_W-1:0]     prod_y_reg;
    logic [SIZE_W-1:0]     sx_reg;
    logic [SIZE_W-1:0]     sy_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  in_range_reg;

    // output payload
    logic [CHAN_W-1:0]     out_blue_reg;
    logic [CHAN_W-1:0]     out_green_reg;
    logic [CHAN_W-1:0]     out_red_reg;
    logic [COORD_BITS-1:0] dest_col_reg;
    logic [COORD_BITS-1:0] dest_row_reg;
    logic                  frame_end_reg;

    logic                  load_ok;
    logic [EDGE_W-1:0]     col_inc;
    logic [EDGE_W-1:0]     row_inc;
    logic                  row_end;
    logic                  last_row;
    logic [SIZE_W-1:0]     sw_eff;
    logic [SIZE_W-1:0]     last_x;
    logic [SIZE_W-1:0]     last_y;
    logic [SCL_W-1:0]      scl_x;
    logic [SCL_W-1:0]      scl_y;
    logic [SIZE_W-1:0]     sx_next;
    logic [SIZE_W-1:0]     sy_next;
    logic [nnis_pkg::PIXEL_W-1:0] rd_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nnis_pkg::SIZE_RESET;
            src_height_reg <= nnis_pkg::SIZE_RESET;
            dst_width_reg  <= nnis_pkg::SIZE_RESET;
            dst_height_reg <= nnis_pkg::SIZE_RESET;
            x_ratio_reg    <= nnis_pkg::RATIO_RESET;
            y_ratio_reg    <= nnis_pkg::RATIO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nnis_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIZE_W-1:0];
                nnis_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[SIZE_W-1:0];
                nnis_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[SIZE_W-1:0];
                nnis_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[SIZE_W-1:0];
                nnis_pkg::REG_X_RATIO:    x_ratio_reg    <= cfg_data;
                nnis_pkg::REG_Y_RATIO:    y_ratio_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // loads past capacity are dropped
    assign load_ok = load_count_reg < LC_W'(PIXEL_CAPACITY);

    // row and frame edges, including the counter wrap limit
    assign col_inc  = EDGE_W'(col_reg) + EDGE_W'(1);
    assign row_inc  = EDGE_W'(row_reg) + EDGE_W'(1);
    assign row_end  = (col_inc >= EDGE_W'(nnis_pkg::at_least_one(dst_width_reg)))
                      || (&col_reg);
    assign last_row = (row_inc >= EDGE_W'(nnis_pkg::at_least_one(dst_height_reg)))
                      || (&row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cmd.load && load_ok)
            begin
                load_count_reg <= load_count_reg + LC_W'(1);
            end
            if (cmd.start)
            begin
                if (!row_end)
                begin
                    col_reg <= col_reg + COORD_BITS'(1);
                end
                else if (!last_row)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + COORD_BITS'(1);
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dcol_reg   <= col_reg;
            drow_reg   <= row_reg;
            fend_reg   <= row_end && last_row;
            prod_x_reg <= PROD_W'(col_reg) * PROD_W'(x_ratio_reg);
            prod_y_reg <= PROD_W'(row_reg) * PROD_W'(y_ratio_reg);
        end
    end

    // floor of coord * Q7.16 ratio, clamped to last source column or row
    assign sw_eff  = nnis_pkg::at_least_one(src_width_reg);
    assign last_x  = sw_eff - SIZE_W'(1);
    assign last_y  = nnis_pkg::at_least_one(src_height_reg) - SIZE_W'(1);
    assign scl_x   = prod_x_reg[PROD_W-1:nnis_pkg::FRAC_BITS];
    assign scl_y   = prod_y_reg[PROD_W-1:nnis_pkg::FRAC_BITS];
    assign sx_next = (CMP_W'(scl_x) > CMP_W'(last_x)) ? last_x : SIZE_W'(scl_x);
    assign sy_next = (CMP_W'(scl_y) > CMP_W'(last_y)) ? last_y : SIZE_W'(scl_y);

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (cmd.index)
        begin
            idx_reg <= IDX_W'(sy_reg) * IDX_W'(sw_eff) + IDX_W'(sx_reg);
        end
        if (cmd.read)
        begin
            in_range_reg <= idx_reg < IDX_W'(PIXEL_CAPACITY);
        end
    end

    nnis_pixel_store #(
        .DEPTH (PIXEL_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && load_ok),
        .waddr (load_count_reg[ADDR_W-1:0]),
        .wdata ({in_red, in_green, in_blue}),
        .re    (cmd.read),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_pixel)
    );

    // index beyond the store gives black
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_blue_reg  <= in_range_reg ? rd_pixel[CHAN_W-1:0] : '0;
            out_green_reg <= in_range_reg ? rd_pixel[2*CHAN_W-1:CHAN_W] : '0;
            out_red_reg   <= in_range_reg ? rd_pixel[3*CHAN_W-1:2*CHAN_W] : '0;
            dest_col_reg  <= dcol_reg;
            dest_row_reg  <= drow_reg;
            frame_end_reg <= fend_reg;
        end
    end

    assign out_blue  = out_blue_reg;
    assign out_green = out_green_reg;
    assign out_red   = out_red_reg;
    assign dest_col  = dest_col_reg;
    assign dest_row  = dest_row_reg;
    assign frame_end = frame_end_reg;

endmodule
